@@ rtl/smlc_pkg.sv @@
// Shared types and constants for the substring match core.
// No dependencies; every other file uses this package.
`default_nettype none

package smlc_pkg;

    // Fixed field widths
    localparam int BYTE_W        = 8;
    localparam int FILE_W        = 8;
    localparam int COUNT_W       = 32;
    localparam int LENGTH_W      = 5;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int PATTERN_BYTES = 16;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = 2;
    localparam int QUEUE_CNT_W   = 3;

    localparam logic [BYTE_W-1:0]  NEWLINE_BYTE = 8'h0A;
    localparam logic [COUNT_W-1:0] COUNTER_MAX  = 32'hFFFF_FFFF;

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_PATTERN_LOW    = 2'd1,
        CFG_PATTERN_HIGH   = 2'd2
    } cfg_index_t;

    // One text byte word
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [FILE_W-1:0] file_number;
        logic              new_file;
    } item_t;

    // One occurrence word
    typedef struct packed {
        logic [FILE_W-1:0]  match_file;
        logic [COUNT_W-1:0] match_line;
        logic [COUNT_W-1:0] match_column;
    } result_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic has_word;
    } queue_status_t;

endpackage

`default_nettype wire

@@ rtl/substring_match_line_column_core.sv @@
// Substring match core: reports every occurrence of a configured pattern of
// 1 to 16 bytes in a byte stream, with the file number, 1-based line and
// 0-based column of its first byte. One text byte is taken every clock cycle
// while the result queue is not full; the window compare over all pattern
// positions is a single parallel stage, so throughput is set only by the
// four-word result queue and the output register, which a result passes
// through in that order. push is refused only while the result queue is full.
// Configuration writes are always ready and take effect on the next byte.
// Depends on smlc_pkg, smlc_front, smlc_queue and smlc_back.
`default_nettype none

module substring_match_line_column_core #(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [smlc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [smlc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire smlc_pkg::item_t                   item,
    input  wire logic                              pop,
    output logic                                   empty,
    output smlc_pkg::result_t                      result
);
    import smlc_pkg::*;

    logic          accept;
    logic          hit;
    result_t       hit_word;
    result_t       q_word;
    logic          q_take;
    queue_status_t q_status;

    assign cfg_ready = 1'b1;
    assign full      = q_status.full;
    assign accept    = push && !full;

    smlc_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .item      (item),
        .hit       (hit),
        .hit_word  (hit_word)
    );

    smlc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .put       (hit),
        .put_word  (hit_word),
        .take      (q_take),
        .head_word (q_word),
        .status    (q_status)
    );

    smlc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .q_word   (q_word),
        .q_take   (q_take),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule

`default_nettype wire

@@ rtl/smlc_front.sv @@
// Front part: configuration registers, byte window, line/column counters
// and the parallel pattern compare. Depends on smlc_pkg.
`default_nettype none

module smlc_front #(
    parameter int MAX_PATTERN = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [smlc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [smlc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              accept,
    input  wire smlc_pkg::item_t                   item,
    output logic                                   hit,
    output smlc_pkg::result_t                      hit_word
);
    import smlc_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [LENGTH_W-1:0]   pat_len_reg;
    logic [CFG_DATA_W-1:0] pat_low_reg;
    logic [CFG_DATA_W-1:0] pat_high_reg;

    logic [BYTE_W-1:0]  byte_win_reg  [MAX_PATTERN];
    logic [COUNT_W-1:0] line_hist_reg [MAX_PATTERN];
    logic [COUNT_W-1:0] col_hist_reg  [MAX_PATTERN];
    logic [COUNT_W-1:0] cur_line_reg;
    logic [COUNT_W-1:0] cur_col_reg;
    logic [LEN_W-1:0]   fill_reg;

    logic [BYTE_W-1:0]  byte_win_next  [MAX_PATTERN];
    logic [COUNT_W-1:0] line_hist_next [MAX_PATTERN];
    logic [COUNT_W-1:0] col_hist_next  [MAX_PATTERN];
    logic [COUNT_W-1:0] cur_line_next;
    logic [COUNT_W-1:0] cur_col_next;
    logic [LEN_W-1:0]   fill_next;

    logic [COUNT_W-1:0] base_line;
    logic [COUNT_W-1:0] base_col;
    logic [LEN_W-1:0]   base_fill;
    logic [LEN_W-1:0]   used_len;
    logic [IDX_W-1:0]   last_idx;
    logic [BYTE_W-1:0]  pat_bytes [MAX_PATTERN];
    logic               all_equal;

    // Unpack pattern bytes; positions past the register pair read as zero
    logic [2*CFG_DATA_W-1:0] pat_all;
    assign pat_all = {pat_high_reg, pat_low_reg};

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_pat
        if (g < PATTERN_BYTES) begin : g_live
            assign pat_bytes[g] = pat_all[BYTE_W*g +: BYTE_W];
        end else begin : g_zero
            assign pat_bytes[g] = '0;
        end
    end

    // Clamp the configured length into 1..MAX_PATTERN
    always_comb
    begin
        if (pat_len_reg == '0)
        begin
            used_len = LEN_W'(1);
        end
        else if (int'(pat_len_reg) > MAX_PATTERN)
        begin
            used_len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            used_len = LEN_W'(pat_len_reg);
        end
    end

    assign last_idx = IDX_W'(used_len - LEN_W'(1));

    // Start of file restarts the counters and empties the window
    assign base_line = item.new_file ? COUNT_W'(1) : cur_line_reg;
    assign base_col  = item.new_file ? '0 : cur_col_reg;
    assign base_fill = item.new_file ? '0 : fill_reg;

    // Shift the new byte in, tagged with its position
    always_comb
    begin
        byte_win_next[0]  = item.data_byte;
        line_hist_next[0] = base_line;
        col_hist_next[0]  = base_col;
        for (int k = 1; k < MAX_PATTERN; k++)
        begin
            byte_win_next[k]  = byte_win_reg[k-1];
            line_hist_next[k] = line_hist_reg[k-1];
            col_hist_next[k]  = col_hist_reg[k-1];
        end
    end

    assign fill_next = (base_fill < LEN_W'(MAX_PATTERN)) ? base_fill + LEN_W'(1) : base_fill;

    // Advance line and column; a newline closes its line
    always_comb
    begin
        if (item.data_byte == NEWLINE_BYTE)
        begin
            cur_line_next = (base_line == COUNTER_MAX) ? base_line : base_line + COUNT_W'(1);
            cur_col_next  = '0;
        end
        else
        begin
            cur_line_next = base_line;
            cur_col_next  = (base_col == COUNTER_MAX) ? base_col : base_col + COUNT_W'(1);
        end
    end

    // Compare every pattern position against the window in parallel
    always_comb
    begin
        logic [IDX_W-1:0] cmp_idx;
        all_equal = 1'b1;
        cmp_idx   = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (LEN_W'(i) < used_len)
            begin
                cmp_idx = IDX_W'(used_len - LEN_W'(1) - LEN_W'(i));
                if (byte_win_next[cmp_idx] != pat_bytes[i])
                begin
                    all_equal = 1'b0;
                end
            end
        end
    end

    assign hit                   = accept && (fill_next >= used_len) && all_equal;
    assign hit_word.match_file   = item.file_number;
    assign hit_word.match_line   = line_hist_next[last_idx];
    assign hit_word.match_column = col_hist_next[last_idx];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg  <= LENGTH_W'(1);
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_PATTERN_LENGTH: pat_len_reg  <= cfg_data[LENGTH_W-1:0];
                CFG_PATTERN_LOW:    pat_low_reg  <= cfg_data;
                CFG_PATTERN_HIGH:   pat_high_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Stream counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_line_reg <= COUNT_W'(1);
            cur_col_reg  <= '0;
            fill_reg     <= '0;
        end
        else if (accept)
        begin
            cur_line_reg <= cur_line_next;
            cur_col_reg  <= cur_col_next;
            fill_reg     <= fill_next;
        end
    end

    // Window contents; entries past the fill count are never looked at
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_win_reg  <= byte_win_next;
            line_hist_reg <= line_hist_next;
            col_hist_reg  <= col_hist_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/smlc_queue.sv @@
// Short first-in first-out queue of occurrence words between front and back.
// Depends on smlc_pkg.
`default_nettype none

module smlc_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   put,
    input  wire smlc_pkg::result_t      put_word,
    input  wire logic                   take,
    output smlc_pkg::result_t           head_word,
    output smlc_pkg::queue_status_t     status
);
    import smlc_pkg::*;

    result_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_put;
    logic                   do_take;

    assign status.full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign status.has_word = (count_reg != '0);
    assign head_word       = slot_reg[rd_ptr_reg];

    assign do_put  = put && !status.full;
    assign do_take = take && status.has_word;

    always_comb
    begin
        count_next = count_reg;
        if (do_put && !do_take)
        begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end
        else if (do_take && !do_put)
        begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_put)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_take)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_put)
        begin
            slot_reg[wr_ptr_reg] <= put_word;
        end
    end

endmodule

`default_nettype wire

@@ rtl/smlc_back.sv @@
// Back part: output register that presents the oldest occurrence word.
// Depends on smlc_pkg.
`default_nettype none

module smlc_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire smlc_pkg::queue_status_t q_status,
    input  wire smlc_pkg::result_t      q_word,
    output logic                        q_take,
    input  wire logic                   pop,
    output logic                        empty,
    output smlc_pkg::result_t           result
);
    import smlc_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_word_reg;

    // Refill whenever the register is free or being drained
    assign q_take = q_status.has_word && (!out_valid_reg || pop);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            out_word_reg <= q_word;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_word_reg;

endmodule

`default_nettype wire

@@ rtl/smlc_checker.sv @@
// Port-level checks for the substring match core, bound to its top level.
// Depends on smlc_pkg and substring_match_line_column_core.
`default_nettype none

module smlc_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic                              push,
    input  wire logic                              full,
    input  wire logic                              pop,
    input  wire logic                              empty,
    input  wire smlc_pkg::result_t                 result
);
    // A waiting word holds until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result word changed while waiting");

    // Lines count from one
    a_line: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.match_line != '0))
        else $error("result line is zero");

    // No word appears without a byte accepted beforehand
    a_source: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !(push && !full) && !$past(push && !full)) |=> empty)
        else $error("result appeared without an accepted byte");

    // Configuration is never back-pressured
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind substring_match_line_column_core smlc_checker u_smlc_checker (.*);

`default_nettype wire
